// ===== design/abtt_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// abtt_pkg: shared types and codes for the array binary tree table unit
// Command and status codes, the empty-slot word and the payload structs of
// the request and response channels.
// ----------------------------------------------------------------------------
package abtt_pkg;

   // command codes
   localparam logic [1:0] CMD_INSERT = 2'd0;
   localparam logic [1:0] CMD_SEARCH = 2'd1;
   localparam logic [1:0] CMD_DELETE = 2'd2;

   // status codes
   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_NO_PARENT = 2'd1;
   localparam logic [1:0] ST_BLOCKED   = 2'd2;
   localparam logic [1:0] ST_NOT_FOUND = 2'd3;

   // all ones marks an empty slot
   localparam logic [31:0] EMPTY_WORD = 32'hFFFF_FFFF;

   localparam int unsigned SLOT_OUT_W = 7;

   typedef struct packed {
      logic [1:0]         cmd;
      logic signed [31:0] value;
      logic signed [31:0] parent_value;
      logic               go_left;
   } req_type;

   typedef struct packed {
      logic [1:0]            status;
      logic [SLOT_OUT_W-1:0] slot_index;
   } rsp_type;

endpackage : abtt_pkg
`default_nettype wire

// ===== design/array_binary_tree_table_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// array_binary_tree_table_unit: binary tree kept in a flat slot table
// Insert, search and delete over a table whose slot i has its children at
// 2i+1 and 2i+2. At most one linear scan through the table RAM per command.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+-------------------------------
//  req     | in        | req_valid/req_ready  | req_data  (abtt_pkg::req_type)
//  rsp     | out       | rsp_valid/rsp_ready  | rsp_data  (abtt_pkg::rsp_type)
//
//  One command at a time. Search and delete scan from slot 0 until a hit or
//  the last slot, reading one slot a cycle through the table's registered
//  read port. An insert that finds its parent then reads the child slot in
//  S_CHILD_RD and checks it in S_CHILD_CHK; the root insert and an unused
//  command go straight to S_RESP. After reset a clearing pass writes the
//  empty word into every slot, with req_ready low. A stalled response is
//  held in the output register while the next command runs; that command's
//  result then waits, with req_ready low, until the register is free.
//
module array_binary_tree_table_unit #(
   parameter int unsigned TABLE_SLOTS = 128
) (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    req_valid,
   output logic                   req_ready,
   input  wire abtt_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire                    rsp_ready,
   output abtt_pkg::rsp_type      rsp_data
);

   localparam int unsigned IDX_W = $clog2(TABLE_SLOTS);
   localparam int unsigned CH_W  = IDX_W + 2;
   localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(TABLE_SLOTS - 1);
   localparam logic [CH_W-1:0]  SLOTS_CH  = CH_W'(TABLE_SLOTS);
   localparam int unsigned SLOT_PAD = abtt_pkg::SLOT_OUT_W;

   typedef enum logic [5:0] {
      S_CLEAR     = 6'b000001,
      S_IDLE      = 6'b000010,
      S_SCAN      = 6'b000100,
      S_CHILD_RD  = 6'b001000,
      S_CHILD_CHK = 6'b010000,
      S_RESP      = 6'b100000
   } state_type;

   state_type        state_ff, state_in;
   logic [IDX_W-1:0] clr_idx_ff, clr_idx_in;
   logic [IDX_W-1:0] scan_idx_ff, scan_idx_in;
   logic [IDX_W-1:0] cmp_idx_ff, cmp_idx_in;
   logic             data_vld_ff, data_vld_in;
   logic [IDX_W-1:0] child_ff, child_in;
   logic [1:0]       op_ff, op_in;
   logic [31:0]      value_ff, value_in;
   logic [31:0]      key_ff, key_in;
   logic             left_ff, left_in;
   logic [7:0]       count_ff, count_in;
   logic [1:0]       res_status_ff, res_status_in;
   logic [IDX_W-1:0] res_slot_ff, res_slot_in;
   logic             rsp_valid_ff, rsp_valid_in;
   abtt_pkg::rsp_type rsp_ff, rsp_in;

   // table RAM
   logic [31:0]      table_mem [TABLE_SLOTS];
   logic [31:0]      rd_data_ff;
   logic [IDX_W-1:0] rd_addr;
   logic             wr_en;
   logic [IDX_W-1:0] wr_addr;
   logic [31:0]      wr_data;

   logic             hit;
   logic             at_last;
   logic [CH_W-1:0]  child_calc;
   logic [IDX_W+SLOT_PAD-1:0] slot_wide;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         table_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= table_mem[rd_addr];
   end

   assign hit     = data_vld_ff && (rd_data_ff == key_ff);
   assign at_last = data_vld_ff && (cmp_idx_ff == LAST_IDX);

   // child slot of the matched parent
   assign child_calc = {1'b0, cmp_idx_ff, 1'b0} + (left_ff ? CH_W'(1) : CH_W'(2));

   // sequencer
   always_comb begin
      state_in      = state_ff;
      clr_idx_in    = clr_idx_ff;
      scan_idx_in   = scan_idx_ff;
      cmp_idx_in    = cmp_idx_ff;
      data_vld_in   = data_vld_ff;
      child_in      = child_ff;
      op_in         = op_ff;
      value_in      = value_ff;
      key_in        = key_ff;
      left_in       = left_ff;
      count_in      = count_ff;
      res_status_in = res_status_ff;
      res_slot_in   = res_slot_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_in        = rsp_ff;
      rd_addr       = scan_idx_ff;
      wr_en         = 1'b0;
      wr_addr       = '0;
      wr_data       = abtt_pkg::EMPTY_WORD;
      req_ready     = 1'b0;

      // output register drains independently
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_idx_ff;
            clr_idx_in = clr_idx_ff + IDX_W'(1);
            if (clr_idx_ff == LAST_IDX) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               op_in       = req_data.cmd;
               value_in    = req_data.value;
               left_in     = req_data.go_left;
               key_in      = (req_data.cmd == abtt_pkg::CMD_INSERT) ?
                             req_data.parent_value : req_data.value;
               scan_idx_in = '0;
               data_vld_in = 1'b0;
               res_slot_in = '0;
               case (req_data.cmd) inside
                  abtt_pkg::CMD_INSERT: begin
                     if (count_ff == 8'd0) begin
                        // no insert since reset: value becomes the root
                        wr_en         = 1'b1;
                        wr_addr       = '0;
                        wr_data       = req_data.value;
                        count_in      = 8'd1;
                        res_status_in = abtt_pkg::ST_OK;
                        state_in      = S_RESP;
                     end else begin
                        state_in = S_SCAN;
                     end
                  end
                  abtt_pkg::CMD_SEARCH, abtt_pkg::CMD_DELETE: begin
                     state_in = S_SCAN;
                  end
                  default: begin
                     res_status_in = abtt_pkg::ST_NOT_FOUND;
                     state_in      = S_RESP;
                  end
               endcase
            end
         end
         S_SCAN: begin
            // read slot scan_idx, compare slot cmp_idx read last cycle
            cmp_idx_in  = scan_idx_ff;
            data_vld_in = 1'b1;
            scan_idx_in = scan_idx_ff + IDX_W'(1);
            if (hit) begin
               state_in = S_RESP;
               case (op_ff)
                  abtt_pkg::CMD_INSERT: begin
                     if (key_ff == abtt_pkg::EMPTY_WORD) begin
                        res_status_in = abtt_pkg::ST_NO_PARENT;
                     end else if (child_calc >= SLOTS_CH) begin
                        res_status_in = abtt_pkg::ST_BLOCKED;
                     end else begin
                        child_in = child_calc[IDX_W-1:0];
                        state_in = S_CHILD_RD;
                     end
                  end
                  abtt_pkg::CMD_DELETE: begin
                     wr_en         = 1'b1;
                     wr_addr       = cmp_idx_ff;
                     res_status_in = abtt_pkg::ST_OK;
                     res_slot_in   = cmp_idx_ff;
                  end
                  default: begin
                     res_status_in = abtt_pkg::ST_OK;
                     res_slot_in   = cmp_idx_ff;
                  end
               endcase
            end else if (at_last) begin
               state_in      = S_RESP;
               res_status_in = (op_ff == abtt_pkg::CMD_INSERT) ?
                               abtt_pkg::ST_NO_PARENT : abtt_pkg::ST_NOT_FOUND;
            end
         end
         S_CHILD_RD: begin
            rd_addr  = child_ff;
            state_in = S_CHILD_CHK;
         end
         S_CHILD_CHK: begin
            state_in = S_RESP;
            if (rd_data_ff == abtt_pkg::EMPTY_WORD) begin
               wr_en         = 1'b1;
               wr_addr       = child_ff;
               wr_data       = value_ff;
               res_status_in = abtt_pkg::ST_OK;
               res_slot_in   = child_ff;
               if (count_ff != 8'hFF) begin
                  count_in = count_ff + 8'd1;
               end
            end else begin
               res_status_in = abtt_pkg::ST_BLOCKED;
            end
         end
         S_RESP: begin
            // hand the result over once the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in      = 1'b1;
               rsp_in.status     = res_status_ff;
               rsp_in.slot_index = (res_status_ff == abtt_pkg::ST_OK) ?
                                   slot_wide[SLOT_PAD-1:0] : '0;
               state_in          = S_IDLE;
            end
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
   end

   // low bits of the slot number, zero-extended for small tables
   assign slot_wide = {{SLOT_PAD{1'b0}}, res_slot_ff};

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_idx_ff   <= '0;
         count_ff     <= 8'd0;
         rsp_valid_ff <= 1'b0;
         data_vld_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_idx_ff   <= clr_idx_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         data_vld_ff  <= data_vld_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      scan_idx_ff   <= scan_idx_in;
      cmp_idx_ff    <= cmp_idx_in;
      child_ff      <= child_in;
      op_ff         <= op_in;
      value_ff      <= value_in;
      key_ff        <= key_in;
      left_ff       <= left_in;
      res_status_ff <= res_status_in;
      res_slot_ff   <= res_slot_in;
      rsp_ff        <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule : array_binary_tree_table_unit
`default_nettype wire

// ===== sim/tree_table_checker.sv =====
// ----------------------------------------------------------------------------
// tree_table_checker: response checker for the array binary tree table unit
// Watches both channels, keeps its own copy of the slot table and the insert
// counter, works out the answer to every request that transfers, and compares
// each response with the oldest answer still waiting.
// ----------------------------------------------------------------------------
module tree_table_checker
   import abtt_pkg::*;
#(
   parameter int unsigned TABLE_SLOTS = 128
) (
   input  wire              clock,
   input  wire              reset,
   input  wire              req_valid,
   input  wire              req_ready,
   input  req_type          req_data,
   input  wire              rsp_valid,
   input  wire              rsp_ready,
   input  rsp_type          rsp_data,
   output int unsigned      fault_count,
   output int unsigned      outstanding
);

   // shadow of the block's state
   logic [31:0] tree_slots [TABLE_SLOTS];
   logic [7:0]  inserts_done;

   // answers owed by the block, oldest first
   rsp_type     pending_answers [$];

   initial fault_count = 0;

   // lowest slot holding the word, TABLE_SLOTS when absent
   function automatic int unsigned first_slot_with(logic [31:0] word);
      for (int unsigned i = 0; i < TABLE_SLOTS; i++) begin
         if (tree_slots[i] === word)
            return i;
      end
      return TABLE_SLOTS;
   endfunction

   // apply one command to the shadow table and return its answer
   function automatic rsp_type apply_to_tree(req_type item);
      rsp_type     res;
      int unsigned hit;
      int unsigned child;
      res.status     = ST_NOT_FOUND;
      res.slot_index = '0;
      case (item.cmd)
         CMD_INSERT: begin
            if (inserts_done == 8'd0) begin
               // no insert since reset: value becomes the root, parent ignored
               tree_slots[0] = item.value;
               inserts_done  = 8'd1;
               res.status    = ST_OK;
            end else begin
               hit = first_slot_with(item.parent_value);
               if (hit >= TABLE_SLOTS) begin
                  res.status = ST_NO_PARENT;
               end else if (tree_slots[hit] == EMPTY_WORD) begin
                  // a parent of -1 only ever matches an empty slot
                  res.status = ST_NO_PARENT;
               end else begin
                  child = item.go_left ? 2 * hit + 1 : 2 * hit + 2;
                  res.status = ST_BLOCKED;
                  if (child < TABLE_SLOTS) begin
                     if (tree_slots[child] == EMPTY_WORD) begin
                        tree_slots[child] = item.value;
                        if (inserts_done != 8'hFF)
                           inserts_done = inserts_done + 8'd1;
                        res.status     = ST_OK;
                        res.slot_index = SLOT_OUT_W'(child);
                     end
                  end
               end
            end
         end
         CMD_SEARCH, CMD_DELETE: begin
            hit = first_slot_with(item.value);
            if (hit < TABLE_SLOTS) begin
               // delete clears one slot only, children stay orphaned
               if (item.cmd == CMD_DELETE)
                  tree_slots[hit] = EMPTY_WORD;
               res.status     = ST_OK;
               res.slot_index = SLOT_OUT_W'(hit);
            end
         end
         default: begin
            // unused command: no change, not found
         end
      endcase
      return res;
   endfunction

   // sample both channels on the rising edge
   always @(posedge clock) begin : watch
      rsp_type want;
      if (reset) begin
         for (int unsigned i = 0; i < TABLE_SLOTS; i++)
            tree_slots[i] = EMPTY_WORD;
         inserts_done = 8'd0;
         pending_answers.delete();
         outstanding <= 0;
      end else begin
         // response first, so a same-edge request cannot pair with it
         if (rsp_valid && rsp_ready) begin
            if (pending_answers.size() == 0) begin
               fault_count = fault_count + 1;
               if (fault_count <= 10)
                  $display("%0t: response with none owed: status %0d slot %0d",
                           $realtime, rsp_data.status, rsp_data.slot_index);
            end else begin
               want = pending_answers.pop_front();
               if (rsp_data.status !== want.status ||
                   rsp_data.slot_index !== want.slot_index) begin
                  fault_count = fault_count + 1;
                  if (fault_count <= 10)
                     $display({"%0t: mismatch: expected status %0d slot %0d, ",
                               "got status %0d slot %0d"},
                              $realtime, want.status, want.slot_index,
                              rsp_data.status, rsp_data.slot_index);
               end
            end
         end
         if (req_valid && req_ready)
            pending_answers.push_back(apply_to_tree(req_data));
         outstanding <= pending_answers.size();
      end
   end

endmodule : tree_table_checker

// ===== sim/tb_array_binary_tree_table_unit.sv =====
// ----------------------------------------------------------------------------
// tb_array_binary_tree_table_unit: testbench for the binary tree table unit
// Drives directed and random insert, search and delete commands with random
// gaps on both channels; a checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module tb_array_binary_tree_table_unit;
   import abtt_pkg::*;

   localparam int unsigned TREE_SLOTS  = 128;
   localparam int unsigned CYCLE_LIMIT = 600000;
   localparam logic [1:0]  CMD_UNUSED  = 2'd3;
   localparam logic [31:0] ROOT_KEY    = 32'd100;
   localparam logic [31:0] MAX_KEY     = 32'h7FFF_FFFF;
   localparam logic [31:0] MIN_KEY     = 32'h8000_0000;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   req_type     req_data;
   logic        rsp_valid;
   logic        rsp_ready;
   rsp_type     rsp_data;
   int unsigned fault_count;
   int unsigned outstanding;
   int unsigned cycle_count = 0;

   // keys already used, so later commands hit the tree
   logic [31:0] key_pool [$];

   always #4 clock = ~clock;

   array_binary_tree_table_unit #(
      .TABLE_SLOTS (TREE_SLOTS)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   tree_table_checker #(
      .TABLE_SLOTS (TREE_SLOTS)
   ) checker_i (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .fault_count (fault_count),
      .outstanding (outstanding)
   );

   // mostly short gaps, now and then a long one
   function automatic int unsigned pick_gap();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 55)
         return 0;
      if (roll < 90)
         return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   // small keys collide often; extremes and the empty word now and then
   function automatic logic [31:0] pick_key();
      case ($urandom_range(0, 15))
         0:       return EMPTY_WORD;
         1, 2:    return $urandom();
         3:       return MAX_KEY;
         4:       return MIN_KEY;
         default: return $urandom_range(0, 31);
      endcase
   endfunction

   function automatic logic [31:0] pool_key();
      if (key_pool.size() != 0 && $urandom_range(0, 9) < 7)
         return key_pool[$urandom_range(0, key_pool.size() - 1)];
      return pick_key();
   endfunction

   function automatic req_type tree_cmd(logic [1:0] op, logic [31:0] key,
                                        logic [31:0] parent, logic left);
      req_type item;
      item.cmd          = op;
      item.value        = key;
      item.parent_value = parent;
      item.go_left      = left;
      return item;
   endfunction

   // offer one command and hold it until it transfers
   task automatic send_item(input req_type item, input int unsigned gap);
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // stop offering until every owed response has come back
   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   // response side: random stalls, quiet stretches and one long hold-off
   initial begin : rsp_side
      int unsigned gap_left;
      int unsigned hold_left;
      int unsigned rsp_seen;
      int unsigned tick;
      logic        held_once;
      gap_left  = 0;
      hold_left = 0;
      rsp_seen  = 0;
      tick      = 0;
      held_once = 1'b0;
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         tick++;
         if (rsp_valid && rsp_ready && !reset)
            rsp_seen++;
         if (hold_left != 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (!held_once && rsp_seen == 40) begin
            // long hold-off while the request side keeps offering
            held_once = 1'b1;
            hold_left = 400;
            rsp_ready <= 1'b0;
         end else if (gap_left != 0) begin
            gap_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
            if (tick % 600 >= 150 && $urandom_range(0, 3) == 0)
               gap_left = pick_gap();
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // request side and verdict
   initial begin : req_side
      int unsigned n;
      int unsigned op_roll;
      int unsigned gap;
      logic [31:0] key;
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_data  <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // directed: empty table, root, both children, failures, -1 cases
      send_item(tree_cmd(CMD_SEARCH, 32'd5, 32'd0, 1'b0), pick_gap());
      send_item(tree_cmd(CMD_DELETE, 32'd5, 32'd0, 1'b0), pick_gap());
      send_item(tree_cmd(CMD_SEARCH, EMPTY_WORD, 32'd0, 1'b0), pick_gap());
      send_item(tree_cmd(CMD_UNUSED, 32'd0, 32'd0, 1'b0), pick_gap());
      send_item(tree_cmd(CMD_INSERT, ROOT_KEY, EMPTY_WORD, 1'b0), pick_gap());
      send_item(tree_cmd(CMD_INSERT, MAX_KEY, ROOT_KEY, 1'b1), pick_gap());
      send_item(tree_cmd(CMD_INSERT, MIN_KEY, ROOT_KEY, 1'b0), pick_gap());
      send_item(tree_cmd(CMD_INSERT, 32'd7, ROOT_KEY, 1'b1), pick_gap());
      send_item(tree_cmd(CMD_INSERT, 32'd8, 32'd999, 1'b1), pick_gap());
      send_item(tree_cmd(CMD_INSERT, 32'd9, EMPTY_WORD, 1'b1), pick_gap());
      send_item(tree_cmd(CMD_INSERT, EMPTY_WORD, MAX_KEY, 1'b1), pick_gap());
      send_item(tree_cmd(CMD_SEARCH, MIN_KEY, 32'd0, 1'b0), pick_gap());
      send_item(tree_cmd(CMD_SEARCH, EMPTY_WORD, 32'd0, 1'b0), pick_gap());
      send_item(tree_cmd(CMD_DELETE, EMPTY_WORD, 32'd0, 1'b0), pick_gap());
      send_item(tree_cmd(CMD_DELETE, MAX_KEY, 32'd0, 1'b0), pick_gap());
      send_item(tree_cmd(CMD_SEARCH, MAX_KEY, 32'd0, 1'b0), pick_gap());
      send_item(tree_cmd(CMD_INSERT, 32'd0, ROOT_KEY, 1'b1), pick_gap());
      // right spine down to slot 126, then off the end of the table
      send_item(tree_cmd(CMD_INSERT, 32'd201, MIN_KEY, 1'b0), pick_gap());
      send_item(tree_cmd(CMD_INSERT, 32'd202, 32'd201, 1'b0), pick_gap());
      send_item(tree_cmd(CMD_INSERT, 32'd203, 32'd202, 1'b0), pick_gap());
      send_item(tree_cmd(CMD_INSERT, 32'd204, 32'd203, 1'b0), pick_gap());
      send_item(tree_cmd(CMD_INSERT, 32'd205, 32'd204, 1'b0), pick_gap());
      send_item(tree_cmd(CMD_INSERT, 32'd206, 32'd205, 1'b0), pick_gap());
      send_item(tree_cmd(CMD_INSERT, 32'd207, 32'd205, 1'b1), pick_gap());
      send_item(tree_cmd(CMD_UNUSED, EMPTY_WORD, EMPTY_WORD, 1'b1), pick_gap());
      send_item(tree_cmd(CMD_DELETE, 32'd0, 32'd0, 1'b0), pick_gap());
      wait_drained();

      // counter run: -1 under the root's left slot succeeds every time,
      // enough to drive the insert counter into saturation
      for (n = 0; n < 300; n++) begin
         gap = (n < 100) ? 0 : pick_gap();
         if ($urandom_range(0, 7) == 0)
            send_item(tree_cmd(CMD_SEARCH, pick_key(), $urandom(),
                               1'($urandom_range(0, 1))), gap);
         else
            send_item(tree_cmd(CMD_INSERT, EMPTY_WORD, ROOT_KEY, 1'b1), gap);
      end
      wait_drained();

      // random mix, keys mostly drawn from those already inserted
      key_pool = '{ROOT_KEY, MAX_KEY, MIN_KEY, 32'd201, 32'd202, 32'd203,
                   32'd204, 32'd205};
      for (n = 0; n < 100; n++) begin
         op_roll = $urandom_range(0, 99);
         gap     = (n % 60 < 20) ? 0 : pick_gap();
         if (op_roll < 45) begin
            key = pick_key();
            send_item(tree_cmd(CMD_INSERT, key, pool_key(),
                               1'($urandom_range(0, 1))), gap);
            if (key != EMPTY_WORD) begin
               key_pool.push_back(key);
               if (key_pool.size() > 48)
                  key_pool.delete(0);
            end
         end else if (op_roll < 70) begin
            send_item(tree_cmd(CMD_SEARCH, pool_key(), $urandom(),
                               1'($urandom_range(0, 1))), gap);
         end else if (op_roll < 95) begin
            send_item(tree_cmd(CMD_DELETE, pool_key(), $urandom(),
                               1'($urandom_range(0, 1))), gap);
         end else begin
            send_item(tree_cmd(CMD_UNUSED, $urandom(), $urandom(),
                               1'($urandom_range(0, 1))), gap);
         end
      end

      // drain, then allow one full scan for any stray response
      wait_drained();
      repeat (TREE_SLOTS + 16) @(posedge clock);
      if (fault_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule : tb_array_binary_tree_table_unit
